/* rtl/core/kbs_pkg.sv */
package kbs_pkg;

    localparam int KEY_W     = 32;
    localparam int POS_W     = 8;
    localparam int COUNT_W   = 9;
    localparam int STATUS_W  = 2;
    localparam int S_DATA_W  = 40;
    localparam int S_USER_W  = 1;
    localparam int M_DATA_W  = 8;

    localparam logic [KEY_W-1:0] LOWER_MASK = 32'h2020_2020;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_FOUND     = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_FINISH
    } t_state;

endpackage

/* rtl/core/keyword_binary_search.sv */
// Channel   Dir  Handshake             Payload
// s (item)  in   i_s_tvalid/o_s_tready tdata: entry_index, key_word; tuser: opcode
// m (res)   out  o_m_tvalid/i_m_tready tdata: found_index; tuser: status
// cfg       in   i_cfg_wr_en           i_cfg_wr_data: table_count
//
// A write item gives no result. A lookup is accepted in ST_IDLE, issuing the first table
// read; ST_SEARCH does one probe per step (at most clog2(count+1), 9 for 256 entries) on
// the registered table read data; ST_FINISH loads the result. An empty-table lookup goes
// straight to ST_FINISH. Reset is synchronous; table content is not reset.
// A result waiting on i_m_tready does not block accepting the next item.
module keyword_binary_search #(
    parameter int MAX_KEYWORDS = 256
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [kbs_pkg::COUNT_W-1:0]       i_cfg_wr_data,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [kbs_pkg::S_DATA_W-1:0]      i_s_tdata,  // [7:0] entry_index, [39:8] key_word
    input  logic [kbs_pkg::S_USER_W-1:0]      i_s_tuser,  // [0] opcode
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [kbs_pkg::M_DATA_W-1:0]      o_m_tdata,  // [7:0] found_index
    output logic [kbs_pkg::STATUS_W-1:0]      o_m_tuser   // [1:0] status
);

    import kbs_pkg::*;

    localparam int AW = $clog2(MAX_KEYWORDS);
    localparam int CW = $clog2(MAX_KEYWORDS + 1);
    localparam int LW = (CW > COUNT_W) ? CW : COUNT_W;
    localparam int PW = ((AW > POS_W) ? AW : POS_W) + 1;

    t_state r_state, n_state;

    logic [COUNT_W-1:0]  r_table_count;
    logic [CW-1:0]       r_lo, n_lo, r_hi, n_hi;
    logic [AW-1:0]       r_mid, n_mid;
    logic [KEY_W-1:0]    r_key;
    logic [STATUS_W-1:0] r_res_status, n_res_status;
    logic [POS_W-1:0]    r_res_index, n_res_index;
    logic                r_out_valid, n_out_valid;
    logic [STATUS_W-1:0] r_out_status;
    logic [POS_W-1:0]    r_out_index;

    logic                in_fire, load_out, rd_en, wr_en;
    logic [POS_W-1:0]    in_pos;
    logic [KEY_W-1:0]    in_word, entry;
    logic [PW-1:0]       pos_ext;
    logic [LW-1:0]       cnt_ext;
    logic [CW-1:0]       used;
    logic [CW:0]         mid_sum;

    assign in_pos  = i_s_tdata[POS_W-1:0];
    assign in_word = i_s_tdata[POS_W +: KEY_W];
    assign in_fire = i_s_tvalid && o_s_tready;

    assign pos_ext = PW'(in_pos);
    assign wr_en   = in_fire && (i_s_tuser[0] == OP_WRITE) && (pos_ext < PW'(MAX_KEYWORDS));

    assign cnt_ext = LW'(r_table_count);
    assign used    = (cnt_ext > LW'(MAX_KEYWORDS)) ? CW'(MAX_KEYWORDS) : CW'(cnt_ext);

    // midpoint of [n_lo, n_hi)
    assign mid_sum = (CW+1)'(n_lo) + (CW+1)'(n_hi) - (CW+1)'(1);
    assign n_mid   = mid_sum[AW:1];

    kbs_ram #(
        .WIDTH (KEY_W),
        .DEPTH (MAX_KEYWORDS)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (AW'(pos_ext)),
        .i_wr_data (in_word),
        .i_rd_en   (rd_en),
        .i_rd_addr (n_mid),
        .o_rd_data (entry)
    );

    always_comb begin
        n_state      = r_state;
        n_lo         = r_lo;
        n_hi         = r_hi;
        n_res_status = r_res_status;
        n_res_index  = r_res_index;
        o_s_tready   = 1'b0;
        rd_en        = 1'b0;
        load_out     = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_s_tready = 1'b1;
                n_lo       = '0;
                n_hi       = used;
                if (i_s_tvalid && i_s_tuser[0] == OP_LOOKUP) begin
                    if (used == '0) begin
                        n_res_status = STATUS_EMPTY;
                        n_res_index  = '0;
                        n_state      = ST_FINISH;
                    end else begin
                        rd_en   = 1'b1;
                        n_state = ST_SEARCH;
                    end
                end
            end
            ST_SEARCH: begin
                if (entry == r_key) begin
                    n_res_status = STATUS_FOUND;
                    n_res_index  = POS_W'(r_mid);
                    n_state      = ST_FINISH;
                end else begin
                    if (entry > r_key) begin
                        n_hi = CW'(r_mid);
                    end else begin
                        n_lo = CW'(r_mid) + CW'(1);
                    end
                    if (n_lo < n_hi) begin
                        rd_en = 1'b1;
                    end else begin
                        n_res_status = STATUS_NOT_FOUND;
                        n_res_index  = '0;
                        n_state      = ST_FINISH;
                    end
                end
            end
            ST_FINISH: begin
                if (!r_out_valid || i_m_tready) begin
                    load_out = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (load_out) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_out_valid   <= 1'b0;
            r_table_count <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_wr_en) begin
                r_table_count <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo         <= n_lo;
        r_hi         <= n_hi;
        r_res_status <= n_res_status;
        r_res_index  <= n_res_index;
        if (rd_en) begin
            r_mid <= n_mid;
        end
        if (in_fire) begin
            r_key <= in_word | LOWER_MASK;
        end
        if (load_out) begin
            r_out_status <= r_res_status;
            r_out_index  <= r_res_index;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_index;
    assign o_m_tuser  = r_out_status;

endmodule

/* rtl/core/kbs_ram.sv */
module kbs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* dv/testbench.sv */
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import kbs_pkg::*;

    localparam int MAX_KEYWORDS   = 256;
    localparam int QUIET_CYCLES   = 20;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LONG_HOLD_OFF  = 200;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [POS_W-1:0]    index;
    } t_search_result;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_wr_en;
    logic [COUNT_W-1:0]  i_cfg_wr_data;
    logic                i_s_tvalid;
    logic                o_s_tready;
    logic [S_DATA_W-1:0] i_s_tdata;
    logic [S_USER_W-1:0] i_s_tuser;
    logic                o_m_tvalid;
    logic                i_m_tready;
    logic [M_DATA_W-1:0] o_m_tdata;
    logic [STATUS_W-1:0] o_m_tuser;

    logic [KEY_W-1:0] kw_table [MAX_KEYWORDS];
    int unsigned      table_count;
    t_search_result   pending_answers [$];
    t_search_result   oldest_answer;
    int               errors;
    bit               sender_idle_en;
    bit               recv_idle_en;
    int               hold_off;
    int               stall_left;
    int               quiet_cycles = 0;

    keyword_binary_search #(
        .MAX_KEYWORDS (MAX_KEYWORDS)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_s_tvalid    (i_s_tvalid),
        .o_s_tready    (o_s_tready),
        .i_s_tdata     (i_s_tdata),
        .i_s_tuser     (i_s_tuser),
        .o_m_tvalid    (o_m_tvalid),
        .i_m_tready    (i_m_tready),
        .o_m_tdata     (o_m_tdata),
        .o_m_tuser     (o_m_tuser)
    );

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    function automatic t_search_result search_keyword(input logic [KEY_W-1:0] key_in);
        t_search_result   res;
        logic [KEY_W-1:0] key;
        int               n;
        int               lo;
        int               hi;
        int               mid;
        res.status = STATUS_NOT_FOUND;
        res.index  = '0;
        n = (table_count > MAX_KEYWORDS) ? MAX_KEYWORDS : table_count;
        if (n == 0) begin
            res.status = STATUS_EMPTY;
            return res;
        end
        key = key_in | LOWER_MASK;
        lo  = 0;
        hi  = n - 1;
        while (lo <= hi) begin
            mid = (lo + hi) / 2;
            if (kw_table[mid] == key) begin
                res.status = STATUS_FOUND;
                res.index  = mid[POS_W-1:0];
                return res;
            end else if (kw_table[mid] > key) begin
                hi = mid - 1;
            end else begin
                lo = mid + 1;
            end
        end
        return res;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 9);
        return (r < 7) ? $urandom_range(1, 3) : $urandom_range(4, 30);
    endfunction

    // key near an entry of the searched range, with random case, or anything at all
    function automatic logic [KEY_W-1:0] pick_key(input int n);
        int               r;
        logic [KEY_W-1:0] e;
        r = $urandom_range(0, 9);
        if (n == 0 || r >= 7)
            return $urandom;
        e = kw_table[$urandom_range(0, n - 1)];
        if (r < 5)
            return e & ~(LOWER_MASK & $urandom);
        return (r == 5) ? e + 1 : e - 1;
    endfunction

    task automatic send_item(input logic op, input logic [POS_W-1:0] idx,
                             input logic [KEY_W-1:0] word);
        int gap;
        @(negedge i_clk);
        i_s_tvalid = 1'b1;
        i_s_tuser  = op;
        i_s_tdata  = {word, idx};
        @(posedge i_clk);
        while (!o_s_tready)
            @(posedge i_clk);
        if (op == OP_WRITE)
            kw_table[idx] = word;
        else
            pending_answers.push_back(search_keyword(word));
        gap = (sender_idle_en && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
        if (gap > 0) begin
            @(negedge i_clk);
            i_s_tvalid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic write_entry(input logic [POS_W-1:0] idx, input logic [KEY_W-1:0] word);
        send_item(OP_WRITE, idx, word);
    endtask

    task automatic lookup(input logic [KEY_W-1:0] key);
        send_item(OP_LOOKUP, POS_W'($urandom_range(0, 255)), key);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_s_tvalid = 1'b0;
        while (pending_answers.size() != 0)
            @(posedge i_clk);
        repeat (QUIET_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_table_count(input int unsigned v);
        wait_drained();
        @(negedge i_clk);
        i_cfg_wr_en   = 1'b1;
        i_cfg_wr_data = v[COUNT_W-1:0];
        table_count   = v;
        @(negedge i_clk);
        i_cfg_wr_en   = 1'b0;
    endtask

    task automatic fill_sorted(input int n);
        bit [KEY_W-1:0] words [$];
        if (n >= 2) begin
            words.push_back(LOWER_MASK);
            words.push_back('1);
        end
        while (words.size() < n)
            words.push_back($urandom | LOWER_MASK);
        words.sort();
        for (int i = 0; i < n; i++)
            write_entry(POS_W'(i), words[i]);
    endtask

    task automatic random_phase(input int unsigned count_setting, input int n_items);
        int               n;
        logic [POS_W-1:0] idx;
        n = (count_setting > MAX_KEYWORDS) ? MAX_KEYWORDS : count_setting;
        set_table_count(count_setting);
        if (n > 0 && n < MAX_KEYWORDS)
            fill_sorted(n);
        sender_idle_en = ($urandom_range(0, 3) != 0);
        recv_idle_en   = ($urandom_range(0, 3) != 0);
        repeat (n_items) begin
            if ($urandom_range(0, 6) == 0) begin
                // writes outside the searched range, or of an entry's own value, keep it sorted
                if (n < MAX_KEYWORDS) begin
                    write_entry(POS_W'($urandom_range(n, MAX_KEYWORDS - 1)), $urandom);
                end else begin
                    idx = POS_W'($urandom_range(0, MAX_KEYWORDS - 1));
                    write_entry(idx, kw_table[idx]);
                end
            end else begin
                lookup(pick_key(n));
            end
        end
        sender_idle_en = 1'b1;
        recv_idle_en   = 1'b1;
    endtask

    task automatic test_empty_table();
        lookup('0);
        lookup('1);
        lookup($urandom);
    endtask

    task automatic test_load_table();
        fill_sorted(MAX_KEYWORDS);
    endtask

    task automatic test_directed_search();
        set_table_count(MAX_KEYWORDS);
        lookup(kw_table[0]);
        lookup(kw_table[MAX_KEYWORDS - 1]);
        lookup(kw_table[128] ^ LOWER_MASK);
        lookup(kw_table[37] + 1);
        lookup('0);
        set_table_count(1);
        lookup(kw_table[0]);
        lookup(kw_table[1]);
        set_table_count(2);
        lookup(kw_table[1]);
        lookup(kw_table[2]);
        set_table_count(9'h1FF);
        lookup(kw_table[MAX_KEYWORDS - 1]);
        lookup(kw_table[200]);
        set_table_count(300);
        lookup(kw_table[255]);
        set_table_count(0);
        lookup(kw_table[0]);
    endtask

    task automatic test_backpressure();
        set_table_count(MAX_KEYWORDS);
        sender_idle_en = 1'b0;
        recv_idle_en   = 1'b0;
        hold_off       = LONG_HOLD_OFF;
        repeat (24) lookup(pick_key(MAX_KEYWORDS));
        sender_idle_en = 1'b1;
        recv_idle_en   = 1'b1;
    endtask

    task automatic test_unsorted_table();
        set_table_count(16);
        for (int i = 0; i < 16; i++)
            write_entry(POS_W'(i), $urandom_range(0, 1) ? $urandom : ($urandom | LOWER_MASK));
        repeat (20) lookup(pick_key(16));
    endtask

    task automatic test_random_search();
        random_phase(MAX_KEYWORDS, 100);
        random_phase(9'h1FF, 50);
        random_phase(0, 15);
    endtask

    task automatic test_random_small_tables();
        repeat (4)
            random_phase(($urandom_range(0, 7) < 6) ? $urandom_range(1, 24)
                                                   : $urandom_range(25, 96), 25);
    endtask

    // result transfers
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_answers.size() == 0) begin
                errors++;
                $display("%0t: unexpected result status %0d index %0d",
                         $time, o_m_tuser, o_m_tdata);
            end else begin
                oldest_answer = pending_answers.pop_front();
                if (o_m_tuser !== oldest_answer.status) begin
                    errors++;
                    $display("%0t: status expected %0d actual %0d",
                             $time, oldest_answer.status, o_m_tuser);
                end
                if (o_m_tdata !== oldest_answer.index) begin
                    errors++;
                    $display("%0t: found_index expected %0d actual %0d",
                             $time, oldest_answer.index, o_m_tdata);
                end
            end
        end
    end

    always @(negedge i_clk) begin
        if (hold_off > 0) begin
            i_m_tready = 1'b0;
            hold_off--;
        end else if (stall_left > 0) begin
            i_m_tready = 1'b0;
            stall_left--;
        end else if (recv_idle_en && $urandom_range(0, 3) == 0) begin
            i_m_tready = 1'b0;
            stall_left = pick_gap() - 1;
        end else begin
            i_m_tready = 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n        = 1'b0;
        i_cfg_wr_en    = 1'b0;
        i_cfg_wr_data  = '0;
        i_s_tvalid     = 1'b0;
        i_s_tdata      = '0;
        i_s_tuser      = OP_WRITE;
        i_m_tready     = 1'b0;
        hold_off       = 0;
        stall_left     = 0;
        errors         = 0;
        table_count    = 0;
        sender_idle_en = 1'b1;
        recv_idle_en   = 1'b1;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_empty_table();
        test_load_table();
        test_directed_search();
        test_backpressure();
        test_random_search();
        test_unsorted_table();
        test_random_small_tables();

        wait_drained();
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
